FILE: design/segment_master_arbiter_defines.svh
// ----------------------------------------------------------------------------
// Segment master arbiter assertion macros
// Shared concurrent assertion forms, clocked and gated by the sync reset.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_MASTER_ARBITER_DEFINES_SVH
`define SEGMENT_MASTER_ARBITER_DEFINES_SVH

// Same-cycle implication.
`define SMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment_master_arbiter: assertion failed");

// Next-cycle implication.
`define SMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment_master_arbiter: assertion failed");

`endif

FILE: design/sma_pkg.sv
// ----------------------------------------------------------------------------
// Segment master arbiter package
// Types, codes and sizes shared by the arbiter modules.
// ----------------------------------------------------------------------------
package sma_pkg;

    localparam int MAC_W    = 48;
    localparam int TIME_W   = 64;
    localparam int CH_W     = 8;
    localparam int LINK_W   = 2;
    localparam int PACE_W   = 3;
    localparam int SEG_W    = 2;
    localparam int KIND_W   = 2;

    localparam int IN_DATA_W  = 192;  // 190 bits of fields, zero filled
    localparam int OUT_DATA_W = 72;   // 65 bits of fields, zero filled
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;

    // decoupling queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC_KNOWN = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DESK_THRESH   = 8'd3;

    localparam logic [TIME_W-1:0] STALE_LIMIT_RST = 64'd5000000000;
    localparam logic [CH_W-1:0]   DESK_THRESH_RST = 8'd40;

    // segment owner
    localparam logic [SEG_W-1:0] SEG_NONE    = 2'd0;
    localparam logic [SEG_W-1:0] SEG_US      = 2'd1;
    localparam logic [SEG_W-1:0] SEG_FOREIGN = 2'd2;

    // rival kind
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOX     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    // link state
    localparam logic [LINK_W-1:0] LINK_PROBING     = 2'd1;
    localparam logic [LINK_W-1:0] LINK_GRANTING    = 2'd2;
    localparam logic [LINK_W-1:0] LINK_ESTABLISHED = 2'd3;

    localparam logic [PACE_W-1:0] PACE_FOREIGN = 3'd0;

    typedef struct packed {
        logic [MAC_W-1:0]  own_mac;
        logic              own_mac_known;
        logic [TIME_W-1:0] stale_limit;
        logic [CH_W-1:0]   desk_thresh;
    } t_cfg;

    // classified request as it sits in the queue
    typedef struct packed {
        logic              qual;   // live foreign master sighting
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] seen;
        logic [CH_W-1:0]   ch;
        logic [LINK_W-1:0] link;
        logic [PACE_W-1:0] pace;
        logic              last;
    } t_cls;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_state;
        logic              conflict;
        logic [KIND_W-1:0] rival_kind;
        logic [CH_W-1:0]   rival_chans;
        logic [MAC_W-1:0]  master_mac;
        logic              master_mac_valid;
        logic [PACE_W-1:0] pace_source;
    } t_res;

endpackage

FILE: design/segment_master_arbiter.sv
// ----------------------------------------------------------------------------
// Segment master arbiter
// Picks the segment owner from a stream of discovery-table entries.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one discovery-table entry per request; tlast marks the
//   final entry of a table scan and tuser says whether an entry is present.
//   m_axis returns one decision per scan, only for the request with tlast.
//   The cfg channel writes own MAC, its known flag, stale limit and desk
//   threshold; o_cfg_ready is always high, write only while the block idles.
// Path: a last entry goes into the queue, then into the result register
//   driving m_axis_tvalid. Throughput: one request per cycle unless m_axis
//   stalls, set by the single running-best compare in the back end.
// Reset: config returns to own MAC 0 (unknown), stale limit 5 s, desk
//   threshold 40; the queue empties and the running best clears.
// Stall: when m_axis_tready is low the decision is held; the back end stops
//   popping, the two-entry queue fills, and then s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "segment_master_arbiter_defines.svh"

module segment_master_arbiter import sma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // role_is_master[0], entry_mac[48:1], entry_last_seen[112:49],
    // entry_channels[120:113], now_time[184:121], link_state[186:185],
    // home_pace[189:187]
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,   // entry_present[0]
    input  logic                  s_axis_tlast,   // last_entry
    // segment_state[1:0], conflict[2], rival_kind[4:3], rival_chans[12:5],
    // master_mac[60:13], master_mac_valid[61], pace_source[64:62]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic w_full;
    logic w_push;
    t_cls w_cls;
    logic w_q_valid;
    t_cls w_q;
    logic w_pop;
    logic w_res_valid;
    t_res w_res;
    logic w_conflict_seen;
    logic w_owner_us;
    logic w_foreign_seen;
    logic w_foreign_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_mac       <= '0;
            r_cfg.own_mac_known <= 1'b0;
            r_cfg.stale_limit   <= STALE_LIMIT_RST;
            r_cfg.desk_thresh   <= DESK_THRESH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_MAC:       r_cfg.own_mac       <= i_cfg_data[MAC_W-1:0];
                CFG_OWN_MAC_KNOWN: r_cfg.own_mac_known <= i_cfg_data[0];
                CFG_STALE_LIMIT:   r_cfg.stale_limit   <= i_cfg_data;
                CFG_DESK_THRESH:   r_cfg.desk_thresh   <= i_cfg_data[CH_W-1:0];
                default: begin
                    // unmapped index: ignored
                end
            endcase
        end
    end

    sma_front u_front (
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_present (s_axis_tuser),
        .i_last    (s_axis_tlast),
        .i_full    (w_full),
        .i_cfg     (r_cfg),
        .o_ready   (s_axis_tready),
        .o_push    (w_push),
        .o_cls     (w_cls)
    );

    sma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_cls),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_q)
    );

    sma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q         (w_q),
        .i_cfg       (r_cfg),
        .i_res_ready (m_axis_tready),
        .o_pop       (w_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign m_axis_tvalid = w_res_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_res)){1'b0}},
                            w_res.pace_source,
                            w_res.master_mac_valid,
                            w_res.master_mac,
                            w_res.rival_chans,
                            w_res.rival_kind,
                            w_res.conflict,
                            w_res.segment_state};

    assign w_conflict_seen = w_res_valid && w_res.conflict;
    assign w_owner_us      = (w_res.segment_state == SEG_US);
    assign w_foreign_seen  = w_res_valid && (w_res.segment_state == SEG_FOREIGN);
    assign w_foreign_ok    = w_res.master_mac_valid && (w_res.pace_source == PACE_FOREIGN);

    // a conflict is only reported while we own the segment
    `SMA_ASSERT_IMPL(a_conflict_us, i_clk, i_rst_n, w_conflict_seen, w_owner_us)
    // a foreign owner always reports its MAC and foreign pace
    `SMA_ASSERT_IMPL(a_foreign_report, i_clk, i_rst_n, w_foreign_seen, w_foreign_ok)
    // no decision appears without a queued request behind it
    `SMA_ASSERT_NEXT(a_res_from_queue, i_clk, i_rst_n, !w_res_valid && !w_q_valid, !w_res_valid)

endmodule

FILE: design/sma_front.sv
// ----------------------------------------------------------------------------
// Segment master arbiter front end
// Unpacks an incoming request and classifies it as a live foreign master.
// ----------------------------------------------------------------------------
module sma_front import sma_pkg::*; (
    input  logic                  i_valid,
    input  logic [IN_DATA_W-1:0]  i_data,
    input  logic                  i_present,
    input  logic                  i_last,
    input  logic                  i_full,
    input  t_cfg                  i_cfg,
    output logic                  o_ready,
    output logic                  o_push,
    output t_cls                  o_cls
);

    logic              w_master;
    logic [MAC_W-1:0]  w_mac;
    logic [TIME_W-1:0] w_seen;
    logic [TIME_W-1:0] w_now;
    logic [TIME_W-1:0] w_age;
    logic              w_own;
    logic              w_stale;

    assign w_master = i_data[0];
    assign w_mac    = i_data[48:1];
    assign w_seen   = i_data[112:49];
    assign w_now    = i_data[184:121];
    assign w_age    = w_now - w_seen;

    assign w_own   = i_cfg.own_mac_known && (w_mac == i_cfg.own_mac);
    // future timestamps count as live
    assign w_stale = (w_now > w_seen) && (w_age > i_cfg.stale_limit);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cls.qual = i_present && w_master && !w_own && !w_stale;
        o_cls.mac  = w_mac;
        o_cls.seen = w_seen;
        o_cls.ch   = i_data[120:113];
        o_cls.link = i_data[186:185];
        o_cls.pace = i_data[189:187];
        o_cls.last = i_last;
    end

endmodule

FILE: design/sma_queue.sv
// ----------------------------------------------------------------------------
// Segment master arbiter queue
// Short register FIFO between the classifier and the decision stage.
// ----------------------------------------------------------------------------
module sma_queue import sma_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cls  i_data,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_cls  o_data
);

    t_cls              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: design/sma_back.sv
// ----------------------------------------------------------------------------
// Segment master arbiter back end
// Tracks the newest rival and issues the owner decision on the last entry.
// ----------------------------------------------------------------------------
module sma_back import sma_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_valid,
    input  t_cls  i_q,
    input  t_cfg  i_cfg,
    input  logic  i_res_ready,
    output logic  o_pop,
    output logic  o_res_valid,
    output t_res  o_res
);

    logic              r_found;
    logic [MAC_W-1:0]  r_mac;
    logic [TIME_W-1:0] r_seen;
    logic [CH_W-1:0]   r_ch;
    logic              r_out_valid;
    t_res              r_res;

    logic              n_found;
    logic              n_out_valid;
    logic              w_upd;
    logic              b_found;
    logic [MAC_W-1:0]  b_mac;
    logic [CH_W-1:0]   b_ch;
    logic [KIND_W-1:0] w_kind;
    t_res              w_dec;

    assign o_pop       = i_q_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

    // strictly newer wins, so a tie keeps the earlier entry
    assign w_upd   = i_q.qual && (!r_found || (i_q.seen > r_seen));
    assign b_found = r_found || w_upd;
    assign b_mac   = w_upd ? i_q.mac : r_mac;
    assign b_ch    = w_upd ? i_q.ch  : r_ch;

    always_comb begin
        if (b_ch == '0) begin
            w_kind = KIND_UNKNOWN;
        end else if (b_ch >= i_cfg.desk_thresh) begin
            w_kind = KIND_DESK;
        end else begin
            w_kind = KIND_BOX;
        end
    end

    always_comb begin
        w_dec.segment_state    = SEG_NONE;
        w_dec.conflict         = 1'b0;
        w_dec.rival_kind       = KIND_NONE;
        w_dec.rival_chans      = '0;
        w_dec.master_mac       = '0;
        w_dec.master_mac_valid = 1'b0;
        w_dec.pace_source      = i_q.pace;
        priority if ((i_q.link == LINK_ESTABLISHED) || (i_q.link == LINK_GRANTING)) begin
            w_dec.segment_state = SEG_US;
            if (b_found) begin
                w_dec.conflict       = 1'b1;
                w_dec.rival_kind     = w_kind;
                w_dec.rival_chans    = b_ch;
            end
            if (i_cfg.own_mac_known) begin
                w_dec.master_mac       = i_cfg.own_mac;
                w_dec.master_mac_valid = 1'b1;
            end
        end else if (b_found) begin
            w_dec.segment_state    = SEG_FOREIGN;
            w_dec.master_mac       = b_mac;
            w_dec.master_mac_valid = 1'b1;
            w_dec.rival_kind       = w_kind;
            w_dec.rival_chans      = b_ch;
            w_dec.pace_source      = PACE_FOREIGN;
        end else if (i_q.link == LINK_PROBING) begin
            w_dec.segment_state = SEG_US;
            if (i_cfg.own_mac_known) begin
                w_dec.master_mac       = i_cfg.own_mac;
                w_dec.master_mac_valid = 1'b1;
            end
        end else begin
            w_dec.segment_state = SEG_NONE;
        end
    end

    always_comb begin
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_res_ready;
        if (o_pop) begin
            n_found = i_q.last ? 1'b0 : b_found;
            if (i_q.last) begin
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_upd) begin
            r_mac  <= i_q.mac;
            r_seen <= i_q.seen;
            r_ch   <= i_q.ch;
        end
        if (o_pop && i_q.last) begin
            r_res <= w_dec;
        end
    end

endmodule

FILE: bench/tb_segment_master_arbiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment master arbiter testbench
// Streams discovery-table scans into the arbiter under several register
// settings and checks every decision against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_segment_master_arbiter;
    import sma_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int TOTAL_ITEMS   = 550;
    localparam int PHASE_ITEMS   = 75;
    localparam int DRAIN_CYCLES  = 8;     // decision latency plus queue slack
    localparam int HOLD_CYCLES   = 240;   // long receiver back-pressure
    localparam int STUCK_LIMIT   = 2000;  // cycles without any handshake

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 8'd9;  // no register here
    localparam logic [LINK_W-1:0]    LINK_OTHER = 2'd0;
    localparam logic [MAC_W-1:0]     MAC_MAX    = '1;
    localparam logic [TIME_W-1:0]    T_MAX      = '1;

    // one discovery-table request as the bus carries it
    typedef struct {
        logic              present;
        logic              master;
        logic [MAC_W-1:0]  mac;
        logic [TIME_W-1:0] seen;
        logic [CH_W-1:0]   ch;
        logic [TIME_W-1:0] now;
        logic [LINK_W-1:0] link;
        logic [PACE_W-1:0] pace;
        logic              last;
    } t_entry;

    // predicts each scan decision and matches it against the m_axis output
    class t_arbiter_board;
        logic [MAC_W-1:0]  own_mac;
        logic              own_known;
        logic [TIME_W-1:0] stale_limit;
        logic [CH_W-1:0]   desk_thresh;

        logic              best_found;
        logic [MAC_W-1:0]  best_mac;
        logic [TIME_W-1:0] best_seen;
        logic [CH_W-1:0]   best_ch;

        t_res decisions_q[$];
        int   failures;
        int   checked;
        int   noted;

        function new();
            own_mac     = '0;
            own_known   = 1'b0;
            stale_limit = STALE_LIMIT_RST;
            desk_thresh = DESK_THRESH_RST;
            best_found  = 1'b0;
            best_mac    = '0;
            best_seen   = '0;
            best_ch     = '0;
            failures    = 0;
            checked     = 0;
            noted       = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OWN_MAC:       own_mac     = data[MAC_W-1:0];
                CFG_OWN_MAC_KNOWN: own_known   = data[0];
                CFG_STALE_LIMIT:   stale_limit = data;
                CFG_DESK_THRESH:   desk_thresh = data[CH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [KIND_W-1:0] kind_of(logic [CH_W-1:0] ch);
            if (ch == '0)
                return KIND_UNKNOWN;
            return (ch >= desk_thresh) ? KIND_DESK : KIND_BOX;
        endfunction

        function void note_entry(t_entry e);
            logic is_own;
            logic is_stale;
            t_res d;
            noted++;
            if (e.present && e.master) begin
                is_own   = own_known && (e.mac == own_mac);
                // a sighting from the future counts as live
                is_stale = (e.now > e.seen) && ((e.now - e.seen) > stale_limit);
                // strict compare: on equal time the earlier sighting stays
                if (!is_own && !is_stale && (!best_found || e.seen > best_seen)) begin
                    best_found = 1'b1;
                    best_mac   = e.mac;
                    best_seen  = e.seen;
                    best_ch    = e.ch;
                end
            end
            if (e.last) begin
                d = '0;
                d.pace_source = e.pace;
                if (e.link == LINK_ESTABLISHED || e.link == LINK_GRANTING) begin
                    d.segment_state = SEG_US;
                    if (best_found) begin
                        d.conflict       = 1'b1;
                        d.rival_kind     = kind_of(best_ch);
                        d.rival_chans    = best_ch;
                    end
                    if (own_known) begin
                        d.master_mac       = own_mac;
                        d.master_mac_valid = 1'b1;
                    end
                end else if (best_found) begin
                    d.segment_state    = SEG_FOREIGN;
                    d.master_mac       = best_mac;
                    d.master_mac_valid = 1'b1;
                    d.rival_kind       = kind_of(best_ch);
                    d.rival_chans      = best_ch;
                    d.pace_source      = PACE_FOREIGN;
                end else if (e.link == LINK_PROBING) begin
                    d.segment_state = SEG_US;
                    if (own_known) begin
                        d.master_mac       = own_mac;
                        d.master_mac_valid = 1'b1;
                    end
                end
                decisions_q.push_back(d);
                best_found = 1'b0;
                best_mac   = '0;
                best_seen  = '0;
                best_ch    = '0;
            end
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= 10)
                    $display("decision %0d: %s expected 0x%0h, got 0x%0h",
                             checked, field, want, got);
            end
        endfunction

        function void check_decision(logic [OUT_DATA_W-1:0] bus);
            t_res want;
            checked++;
            if (decisions_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("decision %0d arrived with none pending: 0x%0h", checked, bus);
                return;
            end
            want = decisions_q.pop_front();
            compare("segment_state",    64'(want.segment_state),    64'(bus[1:0]));
            compare("conflict",         64'(want.conflict),         64'(bus[2]));
            compare("rival_kind",       64'(want.rival_kind),       64'(bus[4:3]));
            compare("rival_chans",      64'(want.rival_chans),      64'(bus[12:5]));
            compare("master_mac",       64'(want.master_mac),       64'(bus[60:13]));
            compare("master_mac_valid", 64'(want.master_mac_valid), 64'(bus[61]));
            compare("pace_source",      64'(want.pace_source),      64'(bus[64:62]));
        endfunction

        function int outstanding();
            return decisions_q.size();
        endfunction

        function void close();
            if (decisions_q.size() != 0) begin
                $display("%0d decisions never arrived", decisions_q.size());
                failures += decisions_q.size();
            end
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    t_arbiter_board board;

    // stimulus-side copy of the register values, used to aim at edge cases
    logic [MAC_W-1:0]  cfg_mac;
    logic [TIME_W-1:0] cfg_limit;
    logic [CH_W-1:0]   cfg_thresh;

    int items_sent   = 0;
    int scans_sent   = 0;
    int cfg_sets     = 0;
    int stuck_cycles = 0;
    bit steady       = 1'b0;   // no idling on either side
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;

    segment_master_arbiter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_entry make_entry(
        input logic              present,
        input logic              master,
        input logic [MAC_W-1:0]  mac,
        input logic [TIME_W-1:0] seen,
        input logic [CH_W-1:0]   ch,
        input logic [TIME_W-1:0] now,
        input logic [LINK_W-1:0] link,
        input logic [PACE_W-1:0] pace,
        input logic              last
    );
        t_entry e;
        e.present = present;
        e.master  = master;
        e.mac     = mac;
        e.seen    = seen;
        e.ch      = ch;
        e.now     = now;
        e.link    = link;
        e.pace    = pace;
        e.last    = last;
        return e;
    endfunction

    // offer one request; valid stays high afterwards unless a gap follows
    task automatic put_entry(t_entry e);
        if (!steady) begin
            while ($urandom_range(0, 99) < 31) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, e.pace, e.link, e.now, e.ch, e.seen, e.mac, e.master};
        s_axis_tuser  <= e.present;
        s_axis_tlast  <= e.last;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // stop offering, wait out every pending decision, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one back-to-back burst over every register plus an unmapped index
    task automatic write_config(
        input logic [MAC_W-1:0]  mac,
        input logic              known,
        input logic [TIME_W-1:0] limit,
        input logic [CH_W-1:0]   thresh
    );
        logic [CFG_IDX_W-1:0]  idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        drain();
        cfg_mac    = mac;
        cfg_limit  = limit;
        cfg_thresh = thresh;
        idx = '{CFG_OWN_MAC, CFG_OWN_MAC_KNOWN, CFG_STALE_LIMIT, CFG_DESK_THRESH, CFG_SPARE};
        val = '{{16'h0, mac}, {63'h0, known}, limit, {56'h0, thresh}, rand64()};
        for (int k = 0; k < 5; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        cfg_sets++;
    endtask

    // one table scan with random content, ages aimed at the stale boundary
    task automatic random_scan(int len);
        t_entry            e;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] prev_seen;
        prev_seen = rand64();
        for (int k = 0; k < len; k++) begin
            e.present = ($urandom_range(0, 9) != 0);
            e.master  = ($urandom_range(0, 4) != 0);
            e.mac     = ($urandom_range(0, 5) == 0) ? cfg_mac : 48'(rand64());
            e.now     = rand64();
            case ($urandom_range(0, 5))
                0: age = '0;
                1: age = cfg_limit;
                2: age = cfg_limit + 64'd1;
                3: age = (cfg_limit == T_MAX) ? rand64() : rand64() % (cfg_limit + 64'd1);
                4: age = -(64'(1 + $urandom_range(0, 1000)));  // seen in the future
                default: age = rand64();
            endcase
            e.seen = e.now - age;
            // same timestamp as the previous sighting, heard right now
            if ($urandom_range(0, 5) == 0) begin
                e.seen = prev_seen;
                e.now  = prev_seen;
            end
            prev_seen = e.seen;
            case ($urandom_range(0, 4))
                0: e.ch = '0;
                1: e.ch = cfg_thresh - 8'd1;
                2: e.ch = cfg_thresh;
                3: e.ch = '1;
                default: e.ch = 8'($urandom);
            endcase
            e.link = 2'($urandom_range(0, 3));
            e.pace = 3'($urandom_range(0, 7));
            e.last = (k == len - 1);
            put_entry(e);
        end
        scans_sent++;
    endtask

    // bus monitor: requests, decisions and register writes at the same edge
    always @(posedge i_clk) begin : bus_monitor
        t_entry e;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                e.present = s_axis_tuser;
                e.master  = s_axis_tdata[0];
                e.mac     = s_axis_tdata[48:1];
                e.seen    = s_axis_tdata[112:49];
                e.ch      = s_axis_tdata[120:113];
                e.now     = s_axis_tdata[184:121];
                e.link    = s_axis_tdata[186:185];
                e.pace    = s_axis_tdata[189:187];
                e.last    = s_axis_tlast;
                board.note_entry(e);
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_decision(m_axis_tdata);
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    // watchdog: any handshake resets the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no handshake for %0d cycles", STUCK_LIMIT);
            $display("segment_master_arbiter regression: fail");
            $finish;
        end
    end

    // decision receiver: random stalls, one long hold-off to fill the queue
    initial begin : receiver
        int held;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_done = 1'b1;
            end else begin
                m_axis_tready <= steady || ($urandom_range(0, 99) >= 31);
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_start;
        int len;
        board      = new();
        cfg_mac    = '0;
        cfg_limit  = STALE_LIMIT_RST;
        cfg_thresh = DESK_THRESH_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed, reset register values ----
        // empty table, nothing to arbitrate
        put_entry(make_entry(1'b0, 1'b1, '0, '0, '0, '0, LINK_OTHER, 3'd4, 1'b1));
        // empty table while probing, out-of-range pace passes through
        put_entry(make_entry(1'b0, 1'b0, MAC_MAX, T_MAX, 8'd255, T_MAX, LINK_PROBING,
                             3'd7, 1'b1));
        // future timestamp is live; non-master on the last request is skipped
        put_entry(make_entry(1'b1, 1'b1, 48'h0A0B_0C0D_0E0F, 64'd100, 8'd0, 64'd50,
                             LINK_OTHER, 3'd1, 1'b0));
        put_entry(make_entry(1'b1, 1'b0, 48'h1111_2222_3333, 64'd200, 8'd9, 64'd200,
                             LINK_OTHER, 3'd2, 1'b1));
        // age exactly at the limit is live, a tie keeps the first, limit+1 is stale
        put_entry(make_entry(1'b1, 1'b1, 48'h2000_0000_0001, 64'd1000, 8'd40,
                             64'd5000001000, LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h2000_0000_0002, 64'd1000, 8'd39,
                             64'd5000001000, LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h2000_0000_0003, 64'd2000, 8'd200,
                             64'd5000002001, LINK_OTHER, 3'd0, 1'b0));
        // absent entry ignored while established; granting with a rival gives a conflict
        put_entry(make_entry(1'b0, 1'b1, 48'h2000_0000_0004, T_MAX, 8'd1, T_MAX,
                             LINK_ESTABLISHED, 3'd3, 1'b1));
        put_entry(make_entry(1'b1, 1'b1, 48'h3000_0000_0001, 64'd10, 8'd39, 64'd10,
                             LINK_GRANTING, 3'd2, 1'b1));
        // extremes: all-ones fields, a hugely stale sighting, foreign while probing
        put_entry(make_entry(1'b1, 1'b1, MAC_MAX, T_MAX, 8'd255, '0, LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, '0, '0, 8'd1, T_MAX, LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h5, '0, 8'd0, '0, LINK_PROBING, 3'd5, 1'b1));

        // ---- own MAC known, zero stale limit, threshold one ----
        write_config(48'h0123_4567_89AB, 1'b1, '0, 8'd1);
        put_entry(make_entry(1'b1, 1'b1, 48'h0123_4567_89AB, 64'd500, 8'd8, 64'd500,
                             LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h4000_0000_0001, 64'd499, 8'd8, 64'd500,
                             LINK_OTHER, 3'd0, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h4000_0000_0002, 64'd500, 8'd1, 64'd500,
                             LINK_ESTABLISHED, 3'd6, 1'b1));
        // probing unopposed reports our own MAC
        put_entry(make_entry(1'b1, 1'b1, 48'h0123_4567_89AB, 64'd700, 8'd3, 64'd700,
                             LINK_PROBING, 3'd1, 1'b1));
        put_entry(make_entry(1'b0, 1'b0, '0, '0, '0, '0, LINK_OTHER, 3'd3, 1'b1));

        // ---- own MAC zero, no staleness, threshold zero ----
        write_config('0, 1'b1, T_MAX, 8'd0);
        put_entry(make_entry(1'b1, 1'b1, '0, 64'd9, 8'd2, 64'd9, LINK_OTHER, 3'd4, 1'b0));
        put_entry(make_entry(1'b1, 1'b1, 48'h1, '0, 8'd1, T_MAX, LINK_OTHER, 3'd4, 1'b1));
        put_entry(make_entry(1'b1, 1'b1, 48'h2, 64'd5, 8'd0, 64'd5, LINK_ESTABLISHED,
                             3'd4, 1'b1));

        // ---- random scans, one register setting per phase ----
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            case (phase)
                0: write_config(48'(rand64()), 1'b0, STALE_LIMIT_RST, DESK_THRESH_RST);
                1: write_config(MAC_MAX, 1'b1, '0, 8'd1);
                2: write_config(48'(rand64()), 1'b1, 64'($urandom_range(0, 5000)), 8'd255);
                3: write_config('0, 1'b1, T_MAX, 8'd0);
                default: write_config(48'(rand64()), 1'($urandom_range(0, 1)),
                                      $urandom_range(0, 1) ? rand64()
                                                           : 64'($urandom_range(0, 100000)),
                                      8'($urandom));
            endcase
            steady   = (phase == 2);
            hold_req = (phase == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS) begin
                // short scans under the hold-off so decisions pile up
                if (phase == 3)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(1, 6);
                random_scan(len);
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        board.close();
        $display("%0d table entries in %0d random scans plus directed cases, %0d decisions",
                 board.noted, scans_sent, board.checked);
        $display("%0d register settings, one %0d-cycle receiver hold-off, %0d failures",
                 cfg_sets, HOLD_CYCLES, board.failures);
        if (board.failures == 0)
            $display("segment_master_arbiter regression: pass");
        else
            $display("segment_master_arbiter regression: fail");
        $finish;
    end

endmodule
